// ----- sv/dmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_pkg
// shared widths, register indexes and the controller-to-datapath command
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int IDX_W     = 6;   // load index and store address width
  localparam int POS_W     = 3;   // row / column width of a result
  localparam int DIM_W     = 4;   // dimension register width
  localparam int SUM_W     = 35;  // result width, Q19.16 (sign included in the 19 integer bits)
  localparam int CFG_IDX_W = 2;

  // cycles the controller waits after the final issue for the pipeline
  localparam int DRAIN_CYCLES = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // one multiply-accumulate step issued by the controller
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] a_addr;
    logic [IDX_W-1:0] b_addr;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             first;       // first term of a sum
    logic             last_k;      // last term of a sum
    logic             final_elem;  // last result of the matrix
  } mac_cmd_t;

endpackage
`default_nettype wire

// ----- sv/dmm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_ctrl
// sequencer over i, j, k that issues one multiply-accumulate per cycle
// ----------------------------------------------------------------------------
module dmm_ctrl import dmm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             go_i,
  input  wire logic [DIM_W-1:0] rows_a_i,
  input  wire logic [DIM_W-1:0] inner_dim_i,
  input  wire logic [DIM_W-1:0] cols_b_i,
  output mac_cmd_t              cmd_o,
  output logic                  busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (32'(d) > MAX_DIM) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  state_e state_q, state_d;
  logic [DIM_W-1:0] m_q, m_d, n_q, n_d, p_q, p_d;
  logic [POS_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [1:0]       drain_q, drain_d;
  logic             k_end, j_end, i_end;
  logic [IDX_W:0]   a_lin, b_lin;

  assign k_end = ({1'b0, k_q} == (n_q - DIM_W'(1)));
  assign j_end = ({1'b0, j_q} == (p_q - DIM_W'(1)));
  assign i_end = ({1'b0, i_q} == (m_q - DIM_W'(1)));

  assign a_lin = (IDX_W+1)'(i_q) * (IDX_W+1)'(n_q) + (IDX_W+1)'(k_q);
  assign b_lin = (IDX_W+1)'(k_q) * (IDX_W+1)'(p_q) + (IDX_W+1)'(j_q);

  always_comb begin
    cmd_o.valid      = (state_q == ST_RUN);
    cmd_o.a_addr     = a_lin[IDX_W-1:0];
    cmd_o.b_addr     = b_lin[IDX_W-1:0];
    cmd_o.row        = i_q;
    cmd_o.col        = j_q;
    cmd_o.first      = (k_q == '0);
    cmd_o.last_k     = k_end;
    cmd_o.final_elem = k_end && j_end && i_end;
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    n_d     = n_q;
    p_d     = p_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    drain_d = drain_q;
    case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          m_d     = dim_clamp(rows_a_i);
          n_d     = dim_clamp(inner_dim_i);
          p_d     = dim_clamp(cols_b_i);
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!k_end) begin
          k_d = k_q + POS_W'(1);
        end else begin
          k_d = '0;
          if (!j_end) begin
            j_d = j_q + POS_W'(1);
          end else begin
            j_d = '0;
            if (!i_end) begin
              i_d = i_q + POS_W'(1);
            end else begin
              drain_d = 2'(DRAIN_CYCLES - 1);
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (drain_q == '0) state_d = ST_IDLE;
        else drain_d = drain_q - 2'd1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_q     <= '0;
      n_q     <= '0;
      p_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      n_q     <= n_d;
      p_q     <= p_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      drain_q <= drain_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dmm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmm_datapath
// element stores, multiplier, accumulator and result register
// ----------------------------------------------------------------------------
module dmm_datapath import dmm_pkg::*; #(
  parameter int MAX_DIM      = 8,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire logic                    kind_i,
  input  wire logic [IDX_W-1:0]        index_i,
  input  wire logic [ELEMENT_BITS-1:0] value_i,
  input  wire mac_cmd_t                cmd_i,
  output logic                         out_valid_o,
  output logic [POS_W-1:0]             out_row_o,
  output logic [POS_W-1:0]             out_col_o,
  output logic signed [SUM_W-1:0]      out_value_o,
  output logic                         out_end_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * ELEMENT_BITS;

  logic [ELEMENT_BITS-1:0]        mem_a_q [DEPTH];
  logic [ELEMENT_BITS-1:0]        mem_b_q [DEPTH];
  logic signed [ELEMENT_BITS-1:0] a_rd_q, b_rd_q;
  logic signed [PW-1:0]           prod_q;
  logic signed [SUM_W-1:0]        prod_ext, acc_q, acc_d;
  mac_cmd_t                       tag1_q, tag2_q;
  logic                           ld_ok;
  logic [AW-1:0]                  ld_addr;

  assign ld_ok   = (32'(index_i) < DEPTH);
  assign ld_addr = index_i[AW-1:0];

  // store write on a load beat, read on an issued step
  always_ff @(posedge clk_i) begin
    if (load_i && ld_ok && !kind_i) mem_a_q[ld_addr] <= value_i;
    if (cmd_i.valid) a_rd_q <= mem_a_q[cmd_i.a_addr[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ld_ok && kind_i) mem_b_q[ld_addr] <= value_i;
    if (cmd_i.valid) b_rd_q <= mem_b_q[cmd_i.b_addr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= cmd_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag1_q.valid) prod_q <= a_rd_q * b_rd_q;
  end

  assign prod_ext = SUM_W'(prod_q);
  assign acc_d    = (tag2_q.first ? '0 : acc_q) + prod_ext;

  always_ff @(posedge clk_i) begin
    if (tag2_q.valid) acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= tag2_q.valid && tag2_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag2_q.valid && tag2_q.last_k) begin
      out_row_o   <= tag2_q.row;
      out_col_o   <= tag2_q.col;
      out_value_o <= acc_d;
      out_end_o   <= tag2_q.final_elem;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dense_matrix_multiply.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// loads A and B element by element, then computes C = A*B on the last beat
// ----------------------------------------------------------------------------
// load beat: one cycle, busy stays low, a new beat may follow at once
// last beat: busy while all m*n*p steps issue, then through the drain state;
//   each result strobes after its last term passes the read, product and result registers
// a single shared multiply-accumulate, one step per cycle, sets the pace
// results cannot be stalled by the receiver
// reset: dimension registers return to 8, stores hold no defined contents
// ----------------------------------------------------------------------------
module dense_matrix_multiply import dmm_pkg::*; #(
  parameter int MAX_DIM      = 8,
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration writes
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [DIM_W-1:0]        cfg_data_i,
  // load beats
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    kind_i,
  input  wire logic [IDX_W-1:0]        index_i,
  input  wire logic [ELEMENT_BITS-1:0] value_i,
  input  wire logic                    last_i,
  // result beats
  output logic                         out_valid_o,
  output logic [POS_W-1:0]             out_row_o,
  output logic [POS_W-1:0]             out_col_o,
  output logic signed [SUM_W-1:0]      product_value_o,
  output logic                         end_of_result_o
);

  logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic             load_beat;
  logic             go;
  mac_cmd_t         cmd;

  // dimension registers, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // every accepted beat with an in-range index stores its element; a last beat also kicks off the
  // sequencer, which reads the store in the cycle after the beat so the write lands first
  assign load_beat = start && !busy;
  assign go        = load_beat && last_i;

  dmm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .rows_a_i    (rows_a_q),
    .inner_dim_i (inner_dim_q),
    .cols_b_i    (cols_b_q),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  // stores, multiplier (registered) and accumulator feeding the result reg
  dmm_datapath #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load_beat),
    .kind_i      (kind_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (product_value_o),
    .out_end_o   (end_of_result_o)
  );

endmodule
`default_nettype wire
